// ===== hw/rtl/tlc_pkg.sv =====
package tlc_pkg;

  typedef logic [7:0] chan_t;
  // Channel order inside a pixel: 0 red, 1 green, 2 blue, 3 alpha.
  typedef chan_t [3:0] pix_t;

  typedef enum logic [2:0] {
    BM_NORMAL     = 3'd0,
    BM_LEGACY_MUL = 3'd1,
    BM_MULTIPLY   = 3'd2,
    BM_ADD        = 3'd3,
    BM_SUBTRACT   = 3'd4,
    BM_DARKEN     = 3'd5,
    BM_LIGHTEN    = 3'd6,
    BM_PASS       = 3'd7
  } blend_t;

  typedef enum logic [2:0] {
    MIX_NONE  = 3'd0,
    MIX_ALPHA = 3'd1,
    MIX_RED   = 3'd2,
    MIX_GREEN = 3'd3,
    MIX_BLUE  = 3'd4,
    MIX_AVG   = 3'd5
  } mix_t;

  typedef enum logic [3:0] {
    REG_BLEND_MODE   = 4'd0,
    REG_LAYER_WEIGHT = 4'd1,
    REG_CHANNEL_MIX  = 4'd2,
    REG_INVERT_COLOR = 4'd3
  } reg_idx_t;

  localparam int CHANS       = 4;
  localparam int COLOR_CHANS = 3;
  localparam int ALPHA_CH    = 3;

  localparam logic [8:0]  WEIGHT_FULL = 9'd256;
  localparam logic [7:0]  CHAN_MAX    = 8'd255;
  localparam logic [16:0] ROUND_HALF  = 17'd128;

  // Average of rgb: round(sum * 0.3333), i.e. (sum*3333 + 5000) / 10000.
  // The division is a multiply by ceil(2^36 / 10000), exact over the sum range.
  localparam logic [21:0] AVG_MUL   = 22'd3333;
  localparam logic [21:0] AVG_BIAS  = 22'd5000;
  localparam logic [44:0] AVG_RECIP = 45'd6871948;
  localparam int          AVG_SHIFT = 36;

  // Rounding bias for the divide by 255*256.
  localparam logic [25:0] DIV_BIAS = 26'd32640;

  typedef struct packed {
    blend_t     mode;
    logic [8:0] weight;      // clamped to 0..256
    logic [8:0] inv_weight;  // 256 - weight
    mix_t       mix;
    logic       invert;
  } cfg_t;

  typedef struct packed {
    pix_t lay;
    pix_t base;
    logic first;
  } pixpair_t;

endpackage

// ===== hw/rtl/tlc_prep.sv =====
module tlc_prep (
  input  logic            clk,
  input  logic            rst_n,
  input  tlc_pkg::cfg_t     cfg,
  input  logic            in_valid,
  output logic            in_ready,
  input  tlc_pkg::pixpair_t in_pix,
  output logic            out_valid,
  input  logic            out_ready,
  output tlc_pkg::pixpair_t out_pix
);
  import tlc_pkg::*;

  logic        s1_valid_r;
  pixpair_t    s1_pix_r;
  logic [21:0] s1_avg_r;
  logic        s2_valid_r;
  pixpair_t    s2_pix_r;

  logic        s1_ready;
  logic        s2_ready;
  logic [9:0]  sum;
  logic [21:0] avg_nxt;
  logic [44:0] avg_prod;
  logic [8:0]  gray_full;
  chan_t       gray;
  pixpair_t    s2_pix_nxt;

  assign s2_ready  = !s2_valid_r || out_ready;
  assign s1_ready  = !s1_valid_r || s2_ready;
  assign in_ready  = s1_ready;
  assign out_valid = s2_valid_r;
  assign out_pix   = s2_pix_r;

  // Stage 1: weighted sum for the rgb average.
  always_comb begin
    sum     = 10'(in_pix.lay[0]) + 10'(in_pix.lay[1]) + 10'(in_pix.lay[2]);
    avg_nxt = 22'(sum) * AVG_MUL + AVG_BIAS;
  end

  // Stage 2: finish the average, then channel selection and inversion.
  always_comb begin
    avg_prod  = 45'(s1_avg_r) * AVG_RECIP;
    gray_full = 9'(avg_prod >> AVG_SHIFT);
    gray      = (gray_full > 9'(CHAN_MAX)) ? CHAN_MAX : gray_full[7:0];

    s2_pix_nxt = s1_pix_r;
    case (cfg.mix)
      MIX_ALPHA: begin
        s2_pix_nxt.lay = {CHAN_MAX, {COLOR_CHANS{s1_pix_r.lay[3]}}};
      end
      MIX_RED: begin
        s2_pix_nxt.lay = {CHAN_MAX, {COLOR_CHANS{s1_pix_r.lay[0]}}};
      end
      MIX_GREEN: begin
        s2_pix_nxt.lay = {CHAN_MAX, {COLOR_CHANS{s1_pix_r.lay[1]}}};
      end
      MIX_BLUE: begin
        s2_pix_nxt.lay = {CHAN_MAX, {COLOR_CHANS{s1_pix_r.lay[2]}}};
      end
      MIX_AVG: begin
        s2_pix_nxt.lay = {CHAN_MAX, {COLOR_CHANS{gray}}};
      end
      default: begin
        s2_pix_nxt.lay = s1_pix_r.lay;
      end
    endcase

    if (cfg.invert) begin
      for (int k = 0; k < COLOR_CHANS; k++) begin
        s2_pix_nxt.lay[k] = ~s2_pix_nxt.lay[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s2_ready) begin
        s2_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_pix_r <= in_pix;
      s1_avg_r <= avg_nxt;
    end
    if (s2_ready && s1_valid_r) begin
      s2_pix_r <= s2_pix_nxt;
    end
  end

endmodule

// ===== hw/rtl/tlc_blend.sv =====
module tlc_blend (
  input  logic            clk,
  input  logic            rst_n,
  input  tlc_pkg::cfg_t     cfg,
  input  logic            in_valid,
  output logic            in_ready,
  input  tlc_pkg::pixpair_t in_pix,
  output logic            out_valid,
  input  logic            out_ready,
  output tlc_pkg::pix_t     out_pix
);
  import tlc_pkg::*;

  logic        s3_valid_r;
  pixpair_t    s3_pix_r;
  logic [16:0] s3_lw_r [CHANS];
  logic [16:0] s3_bv_r [CHANS];
  logic [15:0] s3_lb_r [CHANS];
  logic [16:0] s3_mw_r [CHANS];

  logic        s4_valid_r;
  pix_t        s4_simple_r;
  logic [25:0] s4_prod_r [CHANS];
  logic        s4_div_r;

  logic        s5_valid_r;
  pix_t        s5_pix_r;

  logic        s3_ready;
  logic        s4_ready;
  logic        s5_ready;
  logic [16:0] wv255;
  logic [16:0] lw_nxt [CHANS];
  logic [16:0] bv_nxt [CHANS];
  logic [15:0] lb_nxt [CHANS];
  logic [16:0] mw_nxt [CHANS];
  pix_t        simple_nxt;
  logic [25:0] prod_nxt [CHANS];
  logic        div_nxt;
  pix_t        s5_pix_nxt;

  assign s5_ready  = !s5_valid_r || out_ready;
  assign s4_ready  = !s4_valid_r || s5_ready;
  assign s3_ready  = !s3_valid_r || s4_ready;
  assign in_ready  = s3_ready;
  assign out_valid = s5_valid_r;
  assign out_pix   = s5_pix_r;

  // 255 * (256 - weight), the white or unit term of the first-layer and multiply modes.
  assign wv255 = 17'({cfg.inv_weight, 8'b0}) - 17'(cfg.inv_weight);

  // Stage 3: the channel products.
  always_comb begin
    for (int k = 0; k < CHANS; k++) begin
      lw_nxt[k] = 17'(in_pix.lay[k]) * 17'(cfg.weight);
      bv_nxt[k] = 17'(in_pix.base[k]) * 17'(cfg.inv_weight);
      lb_nxt[k] = 16'(in_pix.lay[k]) * 16'(in_pix.base[k]);
      mw_nxt[k] = wv255 + lw_nxt[k];
    end
  end

  // Stage 4: the modes that need no divide, and the product for the two that do.
  always_comb begin
    logic [16:0] acc;
    logic [7:0]  lws;
    logic [8:0]  sat;
    logic [16:0] op_a;
    logic [8:0]  op_b;
    div_nxt = (cfg.weight != 9'd0) && !s3_pix_r.first &&
              ((cfg.mode == BM_LEGACY_MUL) || (cfg.mode == BM_MULTIPLY));
    for (int k = 0; k < CHANS; k++) begin
      lws = 8'((s3_lw_r[k] + ROUND_HALF) >> 8);
      acc = 17'd0;
      sat = 9'd0;
      if (cfg.weight == 9'd0) begin
        simple_nxt[k] = s3_pix_r.base[k];
      end else if (s3_pix_r.first) begin
        acc           = s3_lw_r[k] + wv255 + ROUND_HALF;
        simple_nxt[k] = acc[15:8];
      end else begin
        case (cfg.mode)
          BM_NORMAL: begin
            acc           = s3_lw_r[k] + s3_bv_r[k] + ROUND_HALF;
            simple_nxt[k] = acc[15:8];
          end
          BM_ADD: begin
            sat           = 9'(s3_pix_r.base[k]) + 9'(lws);
            simple_nxt[k] = sat[8] ? CHAN_MAX : sat[7:0];
          end
          BM_SUBTRACT: begin
            simple_nxt[k] = (s3_pix_r.base[k] > lws) ? (s3_pix_r.base[k] - lws) : 8'd0;
          end
          BM_DARKEN: begin
            if (k == ALPHA_CH) begin
              simple_nxt[k] = s3_pix_r.lay[k];
            end else begin
              simple_nxt[k] = (s3_pix_r.base[k] < lws) ? s3_pix_r.base[k] : lws;
            end
          end
          BM_LIGHTEN: begin
            if (k == ALPHA_CH) begin
              simple_nxt[k] = s3_pix_r.lay[k];
            end else begin
              simple_nxt[k] = (s3_pix_r.base[k] > lws) ? s3_pix_r.base[k] : lws;
            end
          end
          default: begin
            simple_nxt[k] = s3_pix_r.lay[k];
          end
        endcase
      end

      if (cfg.mode == BM_LEGACY_MUL) begin
        op_a = 17'(s3_lb_r[k]);
        op_b = cfg.weight;
      end else begin
        op_a = s3_mw_r[k];
        op_b = 9'(s3_pix_r.base[k]);
      end
      prod_nxt[k] = 26'(op_a) * 26'(op_b);
    end
  end

  // Stage 5: rounded divide by 255*256 as a shift by 8 followed by an exact
  // divide by 255, (t + (t >> 8) + 1) >> 8, valid while the quotient is below 256.
  always_comb begin
    logic [25:0] z;
    logic [17:0] t;
    logic [10:0] q;
    for (int k = 0; k < CHANS; k++) begin
      z = s4_prod_r[k] + DIV_BIAS;
      t = z[25:8];
      q = 11'((19'(t) + 19'(t >> 8) + 19'd1) >> 8);
      if (s4_div_r) begin
        s5_pix_nxt[k] = (q > 11'(CHAN_MAX)) ? CHAN_MAX : q[7:0];
      end else begin
        s5_pix_nxt[k] = s4_simple_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
      s5_valid_r <= 1'b0;
    end else begin
      if (s3_ready) begin
        s3_valid_r <= in_valid;
      end
      if (s4_ready) begin
        s4_valid_r <= s3_valid_r;
      end
      if (s5_ready) begin
        s5_valid_r <= s4_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready && in_valid) begin
      s3_pix_r <= in_pix;
      s3_lw_r  <= lw_nxt;
      s3_bv_r  <= bv_nxt;
      s3_lb_r  <= lb_nxt;
      s3_mw_r  <= mw_nxt;
    end
    if (s4_ready && s3_valid_r) begin
      s4_simple_r <= simple_nxt;
      s4_prod_r   <= prod_nxt;
      s4_div_r    <= div_nxt;
    end
    if (s5_ready && s4_valid_r) begin
      s5_pix_r <= s5_pix_nxt;
    end
  end

endmodule

// ===== hw/rtl/texture_layer_compositor.sv =====
// Blends one texture layer pixel onto the composite pixel below it: optional
// grayscale channel selection, optional rgb inversion, then the weighted blend
// mode from the configuration registers (or a lerp against white for the first
// layer). The block takes one pixel word per clock while in_tready is high and
// returns one result word per pixel, in order. The five register stages are:
// rgb average sum, channel selection, channel products, blend and second
// product, and the divide by 255*256. Each stage holds its own valid bit, so a
// stall on the output fills the bubbles ahead of it before in_tready falls.
// Configuration writes are taken (cfg_ready is always high) and must be made
// while no pixel is in flight; register indexes above three are ignored.
module texture_layer_compositor (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // layer_red, layer_green, layer_blue, layer_alpha,
  // base_red, base_green, base_blue, base_alpha
  input  logic [63:0] in_tdata,
  // first_layer
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_red, out_green, out_blue, out_alpha
  output logic [31:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [8:0]  cfg_data
);
  import tlc_pkg::*;

  blend_t     mode_r;
  logic [8:0] weight_r;
  mix_t       mix_r;
  logic       invert_r;

  cfg_t       cfg;
  pixpair_t   in_pix;
  pixpair_t   mid_pix;
  logic       mid_valid;
  logic       mid_ready;
  pix_t       res_pix;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= BM_NORMAL;
      weight_r <= WEIGHT_FULL;
      mix_r    <= MIX_NONE;
      invert_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BLEND_MODE:   mode_r   <= blend_t'(cfg_data[2:0]);
        REG_LAYER_WEIGHT: weight_r <= cfg_data;
        REG_CHANNEL_MIX:  mix_r    <= mix_t'(cfg_data[2:0]);
        REG_INVERT_COLOR: invert_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.mode       = mode_r;
    cfg.weight     = (weight_r > WEIGHT_FULL) ? WEIGHT_FULL : weight_r;
    cfg.inv_weight = WEIGHT_FULL - cfg.weight;
    cfg.mix        = mix_r;
    cfg.invert     = invert_r;
  end

  always_comb begin
    for (int k = 0; k < CHANS; k++) begin
      in_pix.lay[k]  = in_tdata[8*k +: 8];
      in_pix.base[k] = in_tdata[8*(k + CHANS) +: 8];
    end
    in_pix.first = in_tuser;
  end

  tlc_prep u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_pix    (in_pix),
    .out_valid (mid_valid),
    .out_ready (mid_ready),
    .out_pix   (mid_pix)
  );

  tlc_blend u_blend (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (mid_valid),
    .in_ready  (mid_ready),
    .in_pix    (mid_pix),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_pix   (res_pix)
  );

  assign out_tdata = res_pix;

  // The input side only backs up when a finished word is held at the output.
  a_stall_from_output: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled while the output was free");

  // With the output draining, an accepted word comes out after passing every register stage.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) ##1 out_tready ##1 out_tready ##1 out_tready
      ##1 out_tready |=> out_tvalid)
    else $error("accepted word did not reach the output in time");

endmodule
